// ----- sv/ffsc_pkg.sv -----
// Shared types and constants for the fixed frame checksum parser.
`timescale 1ns / 1ps

package ffsc_pkg;

  localparam logic [7:0]  HDR1       = 8'hFF;
  localparam logic [7:0]  HDR2       = 8'hFE;
  localparam logic [7:0]  CTRL       = 8'h55;
  localparam logic [7:0]  LEN        = 8'h04;
  localparam logic [15:0] HELD_RESET = 16'd224;

  typedef struct packed {
    logic        valid;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        frame_ok;
  } ffsc_result_t;

endpackage

// ----- sv/ffsc_parse.sv -----
// Frame parser state, running checksum and held position values.
`timescale 1ns / 1ps

module ffsc_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            rx_byte,
  output ffsc_pkg::ffsc_result_t res
);

  localparam logic [2:0] PH_HDR1  = 3'd0;
  localparam logic [2:0] PH_HDR2  = 3'd1;
  localparam logic [2:0] PH_CTRL  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CHECK = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [2:0]  payload_count, payload_count_next;
  logic [7:0]  payload_bytes [4];
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] held_x, held_x_next;
  logic [15:0] held_y, held_y_next;
  logic        ok;
  logic        load_payload;

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    held_x_next        = held_x;
    held_y_next        = held_y;
    load_payload       = 1'b0;
    ok                 = (running_sum == rx_byte);
    res                = '0;
    unique case (phase)
      PH_HDR1: begin
        if (rx_byte == ffsc_pkg::HDR1) begin
          phase_next       = PH_HDR2;
          running_sum_next = rx_byte;
        end
      end
      PH_HDR2: begin
        if (rx_byte == ffsc_pkg::HDR2) begin
          phase_next       = PH_CTRL;
          running_sum_next = running_sum + rx_byte;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_CTRL: begin
        if (rx_byte == ffsc_pkg::CTRL) begin
          phase_next       = PH_LEN;
          running_sum_next = running_sum + rx_byte;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_LEN: begin
        if (rx_byte == ffsc_pkg::LEN) begin
          phase_next         = PH_DATA;
          running_sum_next   = running_sum + rx_byte;
          payload_count_next = 3'd0;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_DATA: begin
        load_payload       = 1'b1;
        running_sum_next   = running_sum + rx_byte;
        payload_count_next = payload_count + 3'd1;
        if (payload_count_next[2]) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next = PH_HDR1;
        if (ok) begin
          held_x_next = {payload_bytes[0], payload_bytes[1]};
          held_y_next = {payload_bytes[2], payload_bytes[3]};
        end
        res.valid    = en;
        res.pos_x    = held_x_next;
        res.pos_y    = held_y_next;
        res.frame_ok = ok;
      end
      default: begin
        phase_next = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR1;
      payload_count <= 3'd0;
      running_sum   <= 8'd0;
      held_x        <= ffsc_pkg::HELD_RESET;
      held_y        <= ffsc_pkg::HELD_RESET;
    end else if (en) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      held_x        <= held_x_next;
      held_y        <= held_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && load_payload) begin
      payload_bytes[payload_count[1:0]] <= rx_byte;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_CHECK)
    else $error("parser phase out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (payload_count <= 3'd3))
    else $error("payload count overran in data phase");

  a_result_on_check: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> (phase == PH_HDR1))
    else $error("parser did not return to idle after checksum byte");

endmodule

// ----- sv/fixed_frame_sum_checksum_parser_core.sv -----
// Top level: input register, frame parser and result register.
// A checksum byte passes the input register and then the result register to the master side.
// Throughput: one byte per cycle unless a result is stalled; single input and result registers set it.
// A stalled result holds the input stage, so at most one byte waits behind it.
// Reset (rst, synchronous, active high): parser idle, running sum zero, held values 224.
`timescale 1ns / 1ps

module fixed_frame_sum_checksum_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] pos_x, [31:16] pos_y
  output logic        m_tuser    // [0] frame_ok
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   advance;
  logic                   s_accept;
  ffsc_pkg::ffsc_result_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte <= s_tdata;
    end
  end

  ffsc_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {res.pos_y, res.pos_x};
      m_tuser <= res.frame_ok;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stage stalled");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending request");

  a_input_drains: assert property (@(posedge clk) disable iff (rst)
    (advance && !s_accept) |=> !in_valid)
    else $error("input register kept a consumed byte");

endmodule
